/* rtl/core/sfa_pkg.sv */
// Shared types, codes and the control program of the sprite frame animator.
// Used by every other file of the project; depends on nothing.
package sfa_pkg;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_PLAY    = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_JUMP    = 3'd3,
    MODE_RESTART = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TILE_WIDTH   = 3'd2,
    REG_TILE_HEIGHT  = 3'd3,
    REG_FIRST_FRAME  = 3'd4,
    REG_LAST_FRAME   = 3'd5,
    REG_FRAME_PERIOD = 3'd6,
    REG_LOOP_ENABLE  = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NONE,
    OP_DECODE,
    OP_DIV1_LOAD,
    OP_DIV2_LOAD,
    OP_DIV_STEP,
    OP_MUL_X,
    OP_MUL_Y,
    OP_BAD,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_NO_SET,
    COND_TW_ZERO,
    COND_DIV_MORE,
    COND_Q_ZERO,
    COND_OUT_BUSY
  } cond_e;

  localparam int unsigned StepW = 4;

  localparam logic [StepW-1:0] StepIdle     = 4'd0;
  localparam logic [StepW-1:0] StepDecode   = 4'd1;
  localparam logic [StepW-1:0] StepDiv1Load = 4'd2;
  localparam logic [StepW-1:0] StepDiv1Run  = 4'd3;
  localparam logic [StepW-1:0] StepDiv2Load = 4'd4;
  localparam logic [StepW-1:0] StepDiv2Run  = 4'd5;
  localparam logic [StepW-1:0] StepMulX     = 4'd6;
  localparam logic [StepW-1:0] StepMulY     = 4'd7;
  localparam logic [StepW-1:0] StepBad      = 4'd8;
  localparam logic [StepW-1:0] StepEmit     = 4'd15;

  localparam int unsigned CfgDataW = 24;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [11:0] tile_width;
    logic [11:0] tile_height;
    logic [15:0] first_frame;
    logic [15:0] last_frame;
    logic [23:0] frame_period;
    logic        loop_enable;
  } cfg_t;

  typedef struct packed {
    logic set_req;
    logic tw_zero;
    logic div_more;
    logic q_zero;
  } dp_stat_t;

  typedef struct packed {
    logic     start;
    logic     out_busy;
    dp_stat_t dp;
  } seq_cond_t;

  typedef struct packed {
    logic [15:0] current_frame;
    logic [15:0] region_x;
    logic [27:0] region_y;
    logic        region_update;
    logic        region_bad;
    logic        is_playing;
  } res_t;

  // The control program. The step after the emit step wraps to idle.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    begin
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: StepIdle};
      case (step)
        StepIdle:     w = '{op: OP_IDLE, cond: COND_NO_START, target: StepIdle};
        StepDecode:   w = '{op: OP_DECODE, cond: COND_NO_SET, target: StepEmit};
        StepDiv1Load: w = '{op: OP_DIV1_LOAD, cond: COND_TW_ZERO, target: StepBad};
        StepDiv1Run:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: StepDiv1Run};
        StepDiv2Load: w = '{op: OP_DIV2_LOAD, cond: COND_Q_ZERO, target: StepBad};
        StepDiv2Run:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: StepDiv2Run};
        StepMulX:     w = '{op: OP_MUL_X, cond: COND_NEVER, target: StepIdle};
        StepMulY:     w = '{op: OP_MUL_Y, cond: COND_ALWAYS, target: StepEmit};
        StepBad:      w = '{op: OP_BAD, cond: COND_ALWAYS, target: StepEmit};
        StepEmit:     w = '{op: OP_EMIT, cond: COND_OUT_BUSY, target: StepEmit};
        default:      w = '{op: OP_NONE, cond: COND_ALWAYS, target: StepIdle};
      endcase
      return w;
    end
  endfunction

endpackage

/* rtl/core/sfa_seq.sv */
// Microcode sequencer: step counter, control program lookup and conditional jumps.
// Depends on sfa_pkg.
module sfa_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfa_pkg::seq_cond_t cond_i,
  output sfa_pkg::ctrl_t     ctrl_o
);

  logic [sfa_pkg::StepW-1:0] step_q, step_d;
  sfa_pkg::ctrl_t            ctrl;
  logic                      take;

  assign ctrl   = sfa_pkg::ucode(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      sfa_pkg::COND_NEVER:    take = 1'b0;
      sfa_pkg::COND_ALWAYS:   take = 1'b1;
      sfa_pkg::COND_NO_START: take = !cond_i.start;
      sfa_pkg::COND_NO_SET:   take = !cond_i.dp.set_req;
      sfa_pkg::COND_TW_ZERO:  take = cond_i.dp.tw_zero;
      sfa_pkg::COND_DIV_MORE: take = cond_i.dp.div_more;
      sfa_pkg::COND_Q_ZERO:   take = cond_i.dp.q_zero;
      sfa_pkg::COND_OUT_BUSY: take = cond_i.out_busy;
      default:                take = 1'b0;
    endcase
  end

  assign step_d = take ? ctrl.target : step_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sfa_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* rtl/core/sfa_dp.sv */
// Datapath: animation state, command decode, a shared divider and the two multipliers.
// Depends on sfa_pkg; driven by the control word from sfa_seq.
module sfa_dp #(
  parameter int unsigned FRAME_BITS = 16,
  parameter int unsigned TIME_BITS  = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfa_pkg::ctrl_t    ctrl_i,
  input  sfa_pkg::cfg_t     cfg_i,
  input  logic              load_i,
  input  logic [2:0]        mode_i,
  input  logic [15:0]       elapsed_i,
  input  logic [15:0]       target_frame_i,
  output sfa_pkg::dp_stat_t stat_o,
  output sfa_pkg::res_t     res_o
);

  localparam int unsigned DivW = (FRAME_BITS > 16) ? FRAME_BITS : 16;
  localparam int unsigned CntW = $clog2(DivW + 1);
  localparam logic [32:0] TimeMax = (33'd1 << TIME_BITS) - 33'd1;

  logic [2:0]            mode_q;
  logic [15:0]           elapsed_q;
  logic [15:0]           target_q;

  logic [FRAME_BITS-1:0] frame_q;
  logic [TIME_BITS-1:0]  acc_q;
  logic                  run_q;
  logic [15:0]           last_x_q;
  logic [27:0]           last_y_q;
  logic                  upd_q;
  logic                  bad_q;
  logic [FRAME_BITS-1:0] f_q;

  logic [DivW-1:0]       quo_q;
  logic [15:0]           rem_q;
  logic [15:0]           den_q;
  logic [CntW-1:0]       cnt_q;

  logic [FRAME_BITS-1:0] dec_f;
  logic [TIME_BITS-1:0]  dec_acc;
  logic                  dec_run;
  logic                  dec_set;

  logic [32:0]           sum;
  logic [32:0]           sat;
  logic [32:0]           next_ext;
  logic [16:0]           shifted;
  logic                  fits;
  logic [15:0]           rem_d;
  logic [27:0]           prod_x;
  logic [DivW+11:0]      prod_y;
  logic [31:0]           frame_wide;

  always_comb begin
    sum      = 33'(acc_q) + 33'(elapsed_q);
    sat      = (sum > TimeMax) ? TimeMax : sum;
    next_ext = 33'(frame_q) + 33'd1;
    dec_f    = frame_q;
    dec_acc  = acc_q;
    dec_run  = run_q;
    dec_set  = 1'b0;
    case (mode_q)
      sfa_pkg::MODE_TICK: begin
        if (run_q) begin
          if (sat >= 33'(cfg_i.frame_period)) begin
            dec_acc = '0;
            if (next_ext > 33'(cfg_i.last_frame)) begin
              if (cfg_i.loop_enable) begin
                dec_set = 1'b1;
                dec_f   = FRAME_BITS'(cfg_i.first_frame);
              end else begin
                dec_run = 1'b0;
              end
            end else begin
              dec_set = 1'b1;
              dec_f   = FRAME_BITS'(next_ext);
            end
          end else begin
            dec_acc = TIME_BITS'(sat);
          end
        end
      end
      sfa_pkg::MODE_PLAY: dec_run = 1'b1;
      sfa_pkg::MODE_STOP: dec_run = 1'b0;
      sfa_pkg::MODE_JUMP: begin
        dec_set = 1'b1;
        dec_f   = FRAME_BITS'(target_q);
      end
      sfa_pkg::MODE_RESTART: begin
        dec_acc = '0;
        dec_set = 1'b1;
        dec_f   = FRAME_BITS'(cfg_i.first_frame);
      end
      default: dec_set = 1'b0;
    endcase
  end

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign rem_d   = fits ? 16'(shifted - {1'b0, den_q}) : shifted[15:0];

  assign prod_x = 28'(rem_q) * 28'(cfg_i.tile_width);
  assign prod_y = (DivW + 12)'(quo_q) * (DivW + 12)'(cfg_i.tile_height);

  assign stat_o.set_req  = dec_set && (cfg_i.image_width != '0) && (cfg_i.image_height != '0);
  assign stat_o.tw_zero  = cfg_i.tile_width == '0;
  assign stat_o.div_more = cnt_q > CntW'(1);
  assign stat_o.q_zero   = quo_q[15:0] == '0;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mode_q    <= mode_i;
      elapsed_q <= elapsed_i;
      target_q  <= target_frame_i;
    end
    case (ctrl_i.op)
      sfa_pkg::OP_DECODE:  f_q <= dec_f;
      sfa_pkg::OP_DIV1_LOAD: begin
        quo_q <= DivW'(cfg_i.image_width);
        den_q <= 16'(cfg_i.tile_width);
        rem_q <= '0;
      end
      sfa_pkg::OP_DIV2_LOAD: begin
        quo_q <= DivW'(f_q);
        den_q <= quo_q[15:0];
        rem_q <= '0;
      end
      sfa_pkg::OP_DIV_STEP: begin
        quo_q <= {quo_q[DivW-2:0], fits};
        rem_q <= rem_d;
      end
      default: rem_q <= rem_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      acc_q    <= '0;
      run_q    <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
      upd_q    <= 1'b0;
      bad_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (load_i) begin
        upd_q <= 1'b0;
        bad_q <= 1'b0;
      end
      case (ctrl_i.op)
        sfa_pkg::OP_DECODE: begin
          acc_q <= dec_acc;
          run_q <= dec_run;
        end
        sfa_pkg::OP_DIV1_LOAD: cnt_q <= CntW'(DivW);
        sfa_pkg::OP_DIV2_LOAD: cnt_q <= CntW'(DivW);
        sfa_pkg::OP_DIV_STEP:  cnt_q <= cnt_q - 1'b1;
        sfa_pkg::OP_MUL_X:     last_x_q <= prod_x[15:0];
        sfa_pkg::OP_MUL_Y: begin
          last_y_q <= prod_y[27:0];
          frame_q  <= f_q;
          upd_q    <= 1'b1;
        end
        sfa_pkg::OP_BAD:       bad_q <= 1'b1;
        default:               cnt_q <= cnt_q;
      endcase
    end
  end

  assign frame_wide = 32'(frame_q);

  assign res_o.current_frame = frame_wide[15:0];
  assign res_o.region_x      = last_x_q;
  assign res_o.region_y      = last_y_q;
  assign res_o.region_update = upd_q;
  assign res_o.region_bad    = bad_q;
  assign res_o.is_playing    = run_q;

endmodule

/* rtl/core/sprite_frame_animator.sv */
// Top level of the sprite frame animator: configuration registers, handshakes, result register.
// Depends on sfa_pkg, sfa_seq and sfa_dp.
//
// One command beat (tick, play, stop, jump or restart) gives exactly one result beat.
// Beats are handled one at a time by a microcoded sequencer. A command that sets a frame
// runs the shared one-bit-per-cycle divider twice (frames per row, then row and column).
// A frame set is refused for a zero tile width before the divider runs, and for an image
// narrower than a tile after the first division. The next command is accepted while the
// previous result still waits in the output register; the following result then waits in
// its last step until that register is free.
module sprite_frame_animator #(
  parameter int unsigned FRAME_BITS = 16,
  parameter int unsigned TIME_BITS  = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_addr_i,
  input  logic [sfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [15:0]                  elapsed_i,
  input  logic [15:0]                  target_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  current_frame_o,
  output logic [15:0]                  region_x_o,
  output logic [27:0]                  region_y_o,
  output logic                         region_update_o,
  output logic                         region_bad_o,
  output logic                         is_playing_o
);

  sfa_pkg::cfg_t      cfg_q;
  sfa_pkg::ctrl_t     ctrl;
  sfa_pkg::dp_stat_t  dp_stat;
  sfa_pkg::seq_cond_t cond;
  sfa_pkg::res_t      res;
  sfa_pkg::res_t      out_q;
  logic               out_valid_q;
  logic               accept;
  logic               out_busy;
  logic               emit;

  assign in_ready_o = ctrl.op == sfa_pkg::OP_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (ctrl.op == sfa_pkg::OP_EMIT) && !out_busy;

  assign cond.start    = accept;
  assign cond.out_busy = out_busy;
  assign cond.dp       = dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= '0;
      cfg_q.image_height <= '0;
      cfg_q.tile_width   <= 12'd1;
      cfg_q.tile_height  <= 12'd1;
      cfg_q.first_frame  <= '0;
      cfg_q.last_frame   <= '0;
      cfg_q.frame_period <= '0;
      cfg_q.loop_enable  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfa_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i[15:0];
        sfa_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i[15:0];
        sfa_pkg::REG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_wdata_i[11:0];
        sfa_pkg::REG_TILE_HEIGHT:  cfg_q.tile_height  <= cfg_wdata_i[11:0];
        sfa_pkg::REG_FIRST_FRAME:  cfg_q.first_frame  <= cfg_wdata_i[15:0];
        sfa_pkg::REG_LAST_FRAME:   cfg_q.last_frame   <= cfg_wdata_i[15:0];
        sfa_pkg::REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_wdata_i[23:0];
        sfa_pkg::REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_wdata_i[0];
        default:                   cfg_q.loop_enable  <= cfg_q.loop_enable;
      endcase
    end
  end

  sfa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  sfa_dp #(
    .FRAME_BITS (FRAME_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg_q),
    .load_i         (accept),
    .mode_i         (mode_i),
    .elapsed_i      (elapsed_i),
    .target_frame_i (target_frame_i),
    .stat_o         (dp_stat),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_frame_o = out_q.current_frame;
  assign region_x_o      = out_q.region_x;
  assign region_y_o      = out_q.region_y;
  assign region_update_o = out_q.region_update;
  assign region_bad_o    = out_q.region_bad;
  assign is_playing_o    = out_q.is_playing;

endmodule

/* verif/sfa_frame_checker.sv */
// Checker for the sprite frame animator: mirrors the register writes, predicts the
// result beat of every accepted command beat and compares results in order.
// Depends on sfa_pkg.
module sfa_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_addr_i,
  input  logic [sfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [2:0]                   mode_i,
  input  logic [15:0]                  elapsed_i,
  input  logic [15:0]                  target_frame_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  sfa_pkg::res_t                result_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  outstanding_o
);
  import sfa_pkg::*;

  localparam logic [24:0] AccumMax = '1;

  cfg_t        sheet;
  logic [15:0] frame_q;
  logic [24:0] accum_q;
  logic        playing_q;
  logic [15:0] region_x_q;
  logic [27:0] region_y_q;
  logic        updated;
  logic        refused;
  res_t        expected_frames[$];
  res_t        want;
  int unsigned mismatches;
  int unsigned outstanding_q;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding_q;

  function automatic void show_frame(logic [15:0] f);
    logic [15:0] per_row;
    logic [15:0] row;
    logic [15:0] col;
    if (sheet.image_width == 0 || sheet.image_height == 0) begin
      return;
    end
    per_row = (sheet.tile_width == 0) ? 16'd0 : sheet.image_width / sheet.tile_width;
    if (per_row == 0) begin
      refused = 1'b1;
      return;
    end
    row = f / per_row;
    col = f - row * per_row;
    region_x_q = col * sheet.tile_width;
    region_y_q = row * sheet.tile_height;
    frame_q = f;
    updated = 1'b1;
  endfunction

  function automatic res_t advance_animation(logic [2:0] mode, logic [15:0] elapsed,
                                             logic [15:0] target);
    logic [25:0] sum;
    updated = 1'b0;
    refused = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (playing_q) begin
          sum = {1'b0, accum_q} + elapsed;
          accum_q = (sum > AccumMax) ? AccumMax : sum[24:0];
          if (accum_q >= sheet.frame_period) begin
            accum_q = '0;
            if (17'(frame_q) + 17'd1 > 17'(sheet.last_frame)) begin
              if (sheet.loop_enable) begin
                show_frame(sheet.first_frame);
              end else begin
                playing_q = 1'b0;
              end
            end else begin
              show_frame(frame_q + 16'd1);
            end
          end
        end
      end
      MODE_PLAY: playing_q = 1'b1;
      MODE_STOP: playing_q = 1'b0;
      MODE_JUMP: show_frame(target);
      MODE_RESTART: begin
        accum_q = '0;
        show_frame(sheet.first_frame);
      end
      default: ;
    endcase
    return '{current_frame: frame_q, region_x: region_x_q, region_y: region_y_q,
             region_update: updated, region_bad: refused, is_playing: playing_q};
  endfunction

  task automatic compare_field(string field, longint unsigned exp_val,
                               longint unsigned got_val);
    if (exp_val != got_val) begin
      if (mismatches < 10) begin
        $display("mismatch in %s: expected %0d, got %0d", field, exp_val, got_val);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sheet = '0;
      sheet.tile_width = 12'd1;
      sheet.tile_height = 12'd1;
      frame_q = '0;
      accum_q = '0;
      playing_q = 1'b0;
      region_x_q = '0;
      region_y_q = '0;
      expected_frames.delete();
      outstanding_q <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_IMAGE_WIDTH:  sheet.image_width = cfg_wdata_i[15:0];
          REG_IMAGE_HEIGHT: sheet.image_height = cfg_wdata_i[15:0];
          REG_TILE_WIDTH:   sheet.tile_width = cfg_wdata_i[11:0];
          REG_TILE_HEIGHT:  sheet.tile_height = cfg_wdata_i[11:0];
          REG_FIRST_FRAME:  sheet.first_frame = cfg_wdata_i[15:0];
          REG_LAST_FRAME:   sheet.last_frame = cfg_wdata_i[15:0];
          REG_FRAME_PERIOD: sheet.frame_period = cfg_wdata_i[23:0];
          REG_LOOP_ENABLE:  sheet.loop_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          if (mismatches < 10) begin
            $display("result beat with no command waiting: frame %0d", result_i.current_frame);
          end
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          compare_field("current_frame", want.current_frame, result_i.current_frame);
          compare_field("region_x", want.region_x, result_i.region_x);
          compare_field("region_y", want.region_y, result_i.region_y);
          compare_field("region_update", want.region_update, result_i.region_update);
          compare_field("region_bad", want.region_bad, result_i.region_bad);
          compare_field("is_playing", want.is_playing, result_i.is_playing);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_frames.push_back(advance_animation(mode_i, elapsed_i, target_frame_i));
      end
      outstanding_q <= expected_frames.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the sprite frame animator testbench: clock, reset, register programming and
// command stimulus with random idling on both channels, and the final verdict.
// Depends on sfa_pkg, sprite_frame_animator and sfa_frame_checker.
module testbench;
  import sfa_pkg::*;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [2:0]          cfg_addr_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic [2:0]          mode_i         = '0;
  logic [15:0]         elapsed_i      = '0;
  logic [15:0]         target_frame_i = '0;
  logic                out_ready_i    = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [15:0]         current_frame_o;
  logic [15:0]         region_x_o;
  logic [27:0]         region_y_o;
  logic                region_update_o;
  logic                region_bad_o;
  logic                is_playing_o;
  int unsigned         mismatch_count;
  int unsigned         outstanding;
  int                  tx_gap_pct    = 0;
  int                  rx_stall_pct  = 0;
  int                  rx_stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sprite_frame_animator DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .elapsed_i,
    .target_frame_i,
    .out_valid_o,
    .out_ready_i,
    .current_frame_o,
    .region_x_o,
    .region_y_o,
    .region_update_o,
    .region_bad_o,
    .is_playing_o
  );

  sfa_frame_checker checker_i (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .mode_i,
    .elapsed_i,
    .target_frame_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .result_i         ({current_frame_o, region_x_o, region_y_o, region_update_o,
                        region_bad_o, is_playing_o}),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      rx_stall_left <= $urandom_range(10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_command(logic [2:0] mode, logic [15:0] elapsed, logic [15:0] target);
    int gap;
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    elapsed_i <= elapsed;
    target_frame_i <= target;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic program_sheet(cfg_t c);
    cfg_we_i <= 1'b1;
    for (int r = 0; r < 8; r++) begin
      cfg_addr_i <= 3'(r);
      case (reg_e'(r))
        REG_IMAGE_WIDTH:  cfg_wdata_i <= CfgDataW'(c.image_width);
        REG_IMAGE_HEIGHT: cfg_wdata_i <= CfgDataW'(c.image_height);
        REG_TILE_WIDTH:   cfg_wdata_i <= CfgDataW'(c.tile_width);
        REG_TILE_HEIGHT:  cfg_wdata_i <= CfgDataW'(c.tile_height);
        REG_FIRST_FRAME:  cfg_wdata_i <= CfgDataW'(c.first_frame);
        REG_LAST_FRAME:   cfg_wdata_i <= CfgDataW'(c.last_frame);
        REG_FRAME_PERIOD: cfg_wdata_i <= CfgDataW'(c.frame_period);
        default:          cfg_wdata_i <= CfgDataW'(c.loop_enable);
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_sheet();
    cfg_t c;
    c.tile_width = 12'($urandom_range(1, 48));
    c.tile_height = 12'($urandom_range(1, 48));
    if ($urandom_range(9) == 0) begin
      c.tile_width = 12'hFFF;
      c.tile_height = 12'hFFF;
    end
    c.image_width = 16'(c.tile_width * $urandom_range(1, 12) +
                        $urandom_range(0, c.tile_width - 1));
    c.image_height = 16'($urandom_range(1, 65535));
    case ($urandom_range(19))
      0: c.image_width = '0;
      1: c.image_height = '0;
      2: c.image_width = 16'($urandom_range(0, c.tile_width - 1));
      3: c.tile_width = '0;
      4: begin
        c.image_width = 16'hFFFF;
        c.image_height = 16'hFFFF;
      end
      5: c.tile_width = 12'd1;
      default: ;
    endcase
    c.first_frame = 16'($urandom_range(0, 20));
    c.last_frame = c.first_frame + 16'($urandom_range(0, 10));
    case ($urandom_range(9))
      0: c.last_frame = 16'($urandom_range(0, c.first_frame));
      1: begin
        c.first_frame = 16'hFFFF - 16'($urandom_range(0, 3));
        c.last_frame = 16'hFFFF;
      end
      2: begin
        c.first_frame = '0;
        c.last_frame = '0;
      end
      default: ;
    endcase
    c.frame_period = 24'($urandom_range(0, 24));
    case ($urandom_range(9))
      0: c.frame_period = '0;
      1: c.frame_period = 24'hFFFFFF;
      2: c.frame_period = 24'($urandom_range(0, 24'hFFFFFF));
      default: ;
    endcase
    c.loop_enable = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic send_random_command(cfg_t c);
    logic [2:0]  mode;
    logic [15:0] elapsed;
    logic [15:0] target;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      mode = MODE_TICK;
    end else if (pick < 67) begin
      mode = MODE_PLAY;
    end else if (pick < 72) begin
      mode = MODE_STOP;
    end else if (pick < 84) begin
      mode = MODE_JUMP;
    end else if (pick < 95) begin
      mode = MODE_RESTART;
    end else begin
      mode = 3'($urandom_range(7, int'(MODE_RESTART) + 1));
    end
    case ($urandom_range(9))
      7:       elapsed = '0;
      8:       elapsed = 16'hFFFF;
      9:       elapsed = 16'($urandom);
      default: elapsed = 16'($urandom_range(0, 8));
    endcase
    case ($urandom_range(9))
      7:       target = '0;
      8:       target = 16'hFFFF;
      9:       target = 16'($urandom);
      default: target = c.first_frame + 16'($urandom_range(0, 12));
    endcase
    send_command(mode, elapsed, target);
  endtask

  initial begin
    cfg_t sheet;
    int   random_done;
    int   items;
    bit   calm;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gap_pct = 20;
    rx_stall_pct <= 5;
    sheet = '{image_width: 16'd64, image_height: 16'd48, tile_width: 12'd16,
              tile_height: 12'd12, first_frame: 16'd2, last_frame: 16'd5,
              frame_period: 24'd3, loop_enable: 1'b1};
    program_sheet(sheet);
    send_command(MODE_TICK, 16'd7, 16'd0);
    send_command(MODE_PLAY, 16'd0, 16'd0);
    send_command(MODE_TICK, 16'd0, 16'd0);
    send_command(MODE_TICK, 16'd3, 16'd0);
    send_command(MODE_TICK, 16'hFFFF, 16'd0);
    send_command(MODE_JUMP, 16'd0, 16'd7);
    send_command(MODE_TICK, 16'd3, 16'd0);
    send_command(MODE_JUMP, 16'd0, 16'hFFFF);
    send_command(MODE_TICK, 16'd3, 16'd0);
    send_command(MODE_RESTART, 16'd0, 16'd0);
    send_command(MODE_STOP, 16'd0, 16'd0);
    send_command(MODE_TICK, 16'd9, 16'd0);
    send_command(3'(int'(MODE_RESTART) + 1), 16'hFFFF, 16'hFFFF);
    send_command(3'h7, 16'd0, 16'd3);
    send_command(MODE_JUMP, 16'd0, 16'd0);
    drain();

    // No image: frame sets leave everything as it is.
    sheet = '{image_width: 16'd0, image_height: 16'hFFFF, tile_width: 12'hFFF,
              tile_height: 12'hFFF, first_frame: 16'hFFFF, last_frame: 16'hFFFF,
              frame_period: 24'd0, loop_enable: 1'b0};
    program_sheet(sheet);
    send_command(MODE_JUMP, 16'd0, 16'd10);
    send_command(MODE_PLAY, 16'd0, 16'd0);
    send_command(MODE_TICK, 16'd0, 16'd0);
    drain();

    // Widest sheet and the highest frame, which always counts as the end.
    sheet.image_width = 16'hFFFF;
    program_sheet(sheet);
    send_command(MODE_JUMP, 16'd0, 16'hFFFF);
    send_command(MODE_TICK, 16'd0, 16'd0);
    send_command(MODE_PLAY, 16'd0, 16'd0);
    drain();

    // Image narrower than one tile, then a zero tile width.
    sheet = '{image_width: 16'd100, image_height: 16'd10, tile_width: 12'd200,
              tile_height: 12'd5, first_frame: 16'd1, last_frame: 16'd4,
              frame_period: 24'd2, loop_enable: 1'b1};
    program_sheet(sheet);
    send_command(MODE_RESTART, 16'd0, 16'd0);
    send_command(MODE_JUMP, 16'd0, 16'd3);
    drain();
    sheet.tile_width = '0;
    program_sheet(sheet);
    send_command(MODE_JUMP, 16'd0, 16'd1);
    send_command(MODE_TICK, 16'd5, 16'd0);

    random_done = 0;
    while (random_done < 1250) begin
      calm = (random_done >= 1100);
      items = calm ? 1250 - random_done : $urandom_range(60, 160);
      if (!calm && random_done + items > 1100) begin
        items = 1100 - random_done;
      end
      drain();
      tx_gap_pct = calm ? 0 : 10 * $urandom_range(0, 6);
      rx_stall_pct <= calm ? 0 : 4 * $urandom_range(0, 5);
      sheet = random_sheet();
      program_sheet(sheet);
      repeat (items) send_random_command(sheet);
      random_done += items;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sprite_frame_animator.f */
rtl/core/sfa_pkg.sv
rtl/core/sfa_seq.sv
rtl/core/sfa_dp.sv
rtl/core/sprite_frame_animator.sv
verif/sfa_frame_checker.sv
verif/testbench.sv
